// ===== rtl/dcdh_pkg.sv =====
// Constants and types shared by the delayed coincidence decay histogram.
`default_nettype none

package dcdh_pkg;

    localparam int NUM_BINS        = 200;
    localparam int BIN_WIDTH_TICKS = 100000;

    localparam int BIN_W     = $clog2(NUM_BINS + 1);
    localparam int DIV_SHIFT = 32 + $clog2(BIN_WIDTH_TICKS);

    localparam logic [32:0] DIV_RECIP = 33'((65'd1 << DIV_SHIFT) / BIN_WIDTH_TICKS);
    localparam logic [31:0] BIN_WIDTH = 32'(BIN_WIDTH_TICKS);
    localparam logic [39:0] OVF_LIMIT = 40'(NUM_BINS) * 40'(BIN_WIDTH_TICKS);
    localparam logic [BIN_W-1:0] OVF_BIN = BIN_W'(NUM_BINS);
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [15:0] CHARGE_THRESHOLD_RST   = 16'd200;
    localparam logic [31:0] COINCIDENCE_WINDOW_RST = 32'd6000;
    localparam logic [31:0] DECAY_WINDOW_RST       = 32'd200000000;

    typedef enum logic [1:0] {
        REG_CHARGE_THRESHOLD   = 2'd0,
        REG_COINCIDENCE_WINDOW = 2'd1,
        REG_DECAY_WINDOW       = 2'd2
    } reg_index_t;

    typedef enum logic {
        CMD_EVENT = 1'b0,
        CMD_READ  = 1'b1
    } command_t;

endpackage

`default_nettype wire

// ===== rtl/dcdh_if.sv =====
// Valid/ready channel interfaces for detector items and histogram results.
`default_nettype none

interface dcdh_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] charge_a;
    logic [15:0] charge_b;
    logic [63:0] time_a;
    logic [63:0] time_b;
    logic [7:0]  bin_index;

    modport source (
        output valid, command, charge_a, charge_b, time_a, time_b, bin_index,
        input  ready
    );
    modport sink (
        input  valid, command, charge_a, charge_b, time_a, time_b, bin_index,
        output ready
    );
endinterface

interface dcdh_result_if;
    logic        valid;
    logic        ready;
    logic        decay_found;
    logic [31:0] decay_time;
    logic [7:0]  decay_bin;
    logic [31:0] bin_count;
    logic [31:0] decay_total;

    modport source (
        output valid, decay_found, decay_time, decay_bin, bin_count, decay_total,
        input  ready
    );
    modport sink (
        input  valid, decay_found, decay_time, decay_bin, bin_count, decay_total,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/delayed_coincidence_decay_histogram.sv =====
// Delayed coincidence decay histogram: event qualification, prompt tracking, binned counts.
// Pipeline: eight register stages, I, P, S, C, D, E, F and G, from item to result.
// Throughput: one item per cycle while results are taken; the histogram read-modify-write
// forwards the value just written, so same-bin decays on consecutive cycles do not stall.
// Reset: configuration returns to its defaults, prompt state and the decay total clear, and
// per-bin valid flags clear the histogram at once; no clearing pass is needed.
`default_nettype none

module delayed_coincidence_decay_histogram (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                wr_en,
    input  wire [1:0]          wr_index,
    input  wire [31:0]         wr_data,
    dcdh_item_if.sink          item,
    dcdh_result_if.source      result
);

    localparam int BW = dcdh_pkg::BIN_W;

    // configuration
    logic [15:0] cfg_charge_threshold_reg;
    logic [31:0] cfg_coincidence_window_reg;
    logic [31:0] cfg_decay_window_reg;

    // prompt tracking state
    logic        prompt_held_reg, prompt_held_next;
    logic        decay_logged_reg, decay_logged_next;
    logic [63:0] prompt_time_reg, prompt_time_next;
    logic [31:0] decay_cnt_reg, decay_cnt_next;

    // stage valids and readies
    logic i_vld_reg, p_vld_reg, s_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg, f_vld_reg, g_vld_reg;
    logic i_rdy, p_rdy, s_rdy, c_rdy, d_rdy, e_rdy, f_rdy, g_rdy;
    logic move_ps;

    // stage I: captured item
    dcdh_pkg::command_t i_cmd_reg;
    logic [15:0] i_qa_reg, i_qb_reg;
    logic [63:0] i_ta_reg, i_tb_reg;
    logic [7:0]  i_idx_reg;

    // stage P: qualification
    logic [63:0] diff_ab, diff_ba, mag, early;
    logic        pass_next, coinc_next;
    dcdh_pkg::command_t p_cmd_reg;
    logic        p_use_reg, p_coinc_reg;
    logic [63:0] p_early_reg;
    logic [7:0]  p_idx_reg;

    // stage S: prompt decision
    logic [63:0] delay;
    logic        found_next;
    dcdh_pkg::command_t s_cmd_reg;
    logic        s_found_reg;
    logic [31:0] s_delay_reg, s_total_reg;
    logic [7:0]  s_idx_reg;

    // stage C: reciprocal multiply
    logic [64:0] c_prod_next;
    dcdh_pkg::command_t c_cmd_reg;
    logic        c_found_reg, c_ovf_reg;
    logic [31:0] c_delay_reg, c_total_reg;
    logic [64:0] c_prod_reg;
    logic [7:0]  c_idx_reg;

    // stage D: back multiply
    logic [31:0] q_est, qbw_next;
    dcdh_pkg::command_t d_cmd_reg;
    logic        d_found_reg, d_ovf_reg;
    logic [31:0] d_delay_reg, d_total_reg, d_q_reg, d_qbw_reg;
    logic [7:0]  d_idx_reg;

    // stage E: bin select and read address
    logic [31:0] rem, q_fix;
    logic [BW-1:0] bin_next, addr_next;
    logic        inrange_next;
    dcdh_pkg::command_t e_cmd_reg;
    logic        e_found_reg, e_inrange_reg;
    logic [31:0] e_delay_reg, e_total_reg;
    logic [BW-1:0] e_addr_reg;

    // stage F: histogram data
    logic [31:0]   hist_mem [dcdh_pkg::NUM_BINS + 1];
    logic [dcdh_pkg::NUM_BINS:0] ent_vld_reg;
    logic [31:0]   f_mem_data_reg, f_fwd_data_reg;
    logic          f_ent_vld_reg, f_fwd_hit_reg;
    dcdh_pkg::command_t f_cmd_reg;
    logic          f_found_reg, f_inrange_reg;
    logic [31:0]   f_delay_reg, f_total_reg;
    logic [BW-1:0] f_addr_reg;
    logic [31:0]   cur_count, mem_wdata;
    logic          mem_we;

    // stage G: output register
    logic          g_cmd_read_reg;
    logic          g_found_reg;
    logic [31:0]   g_time_reg, g_count_reg, g_total_reg;
    logic [7:0]    g_bin_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_charge_threshold_reg   <= dcdh_pkg::CHARGE_THRESHOLD_RST;
            cfg_coincidence_window_reg <= dcdh_pkg::COINCIDENCE_WINDOW_RST;
            cfg_decay_window_reg       <= dcdh_pkg::DECAY_WINDOW_RST;
        end
        else if (wr_en)
        begin
            unique case (dcdh_pkg::reg_index_t'(wr_index))
                dcdh_pkg::REG_CHARGE_THRESHOLD:   cfg_charge_threshold_reg   <= wr_data[15:0];
                dcdh_pkg::REG_COINCIDENCE_WINDOW: cfg_coincidence_window_reg <= wr_data;
                dcdh_pkg::REG_DECAY_WINDOW:       cfg_decay_window_reg       <= wr_data;
                default:                          ;
            endcase
        end
    end

    // handshake chain
    assign g_rdy = !g_vld_reg || result.ready;
    assign f_rdy = !f_vld_reg || g_rdy;
    assign e_rdy = !e_vld_reg || f_rdy;
    assign d_rdy = !d_vld_reg || e_rdy;
    assign c_rdy = !c_vld_reg || d_rdy;
    assign s_rdy = !s_vld_reg || c_rdy;
    assign p_rdy = !p_vld_reg || s_rdy;
    assign i_rdy = !i_vld_reg || p_rdy;
    assign item.ready = i_rdy;
    assign move_ps = p_vld_reg && s_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
        end
        else
        begin
            if (i_rdy) i_vld_reg <= item.valid;
            if (p_rdy) p_vld_reg <= i_vld_reg;
            if (s_rdy) s_vld_reg <= p_vld_reg;
            if (c_rdy) c_vld_reg <= s_vld_reg;
            if (d_rdy) d_vld_reg <= c_vld_reg;
            if (e_rdy) e_vld_reg <= d_vld_reg;
            if (f_rdy) f_vld_reg <= e_vld_reg;
            if (g_rdy) g_vld_reg <= f_vld_reg;
        end
    end

    // qualification
    assign diff_ab    = i_ta_reg - i_tb_reg;
    assign diff_ba    = i_tb_reg - i_ta_reg;
    assign mag        = diff_ab[63] ? diff_ba : diff_ab;
    assign early      = (i_ta_reg < i_tb_reg) ? i_ta_reg : i_tb_reg;
    assign coinc_next = mag < {32'd0, cfg_coincidence_window_reg};
    assign pass_next  = (i_qa_reg > cfg_charge_threshold_reg)
                     && (i_qb_reg > cfg_charge_threshold_reg);

    // prompt decision
    assign delay = p_early_reg - prompt_time_reg;

    always_comb
    begin
        prompt_held_next  = prompt_held_reg;
        decay_logged_next = decay_logged_reg;
        prompt_time_next  = prompt_time_reg;
        decay_cnt_next    = decay_cnt_reg;
        found_next        = 1'b0;
        if (move_ps && p_use_reg)
        begin
            if (!prompt_held_reg && p_coinc_reg)
            begin
                prompt_time_next  = p_early_reg;
                prompt_held_next  = 1'b1;
                decay_logged_next = 1'b0;
            end
            else if (!decay_logged_reg)
            begin
                if ((delay[63:32] == 32'd0) && (delay[31:0] < cfg_decay_window_reg))
                begin
                    found_next        = 1'b1;
                    decay_logged_next = 1'b1;
                    prompt_held_next  = 1'b0;
                    if (decay_cnt_reg != dcdh_pkg::COUNT_MAX)
                    begin
                        decay_cnt_next = decay_cnt_reg + 32'd1;
                    end
                end
                else
                begin
                    prompt_time_next = p_early_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prompt_held_reg  <= 1'b0;
            decay_logged_reg <= 1'b0;
            prompt_time_reg  <= 64'd0;
            decay_cnt_reg    <= 32'd0;
        end
        else
        begin
            prompt_held_reg  <= prompt_held_next;
            decay_logged_reg <= decay_logged_next;
            prompt_time_reg  <= prompt_time_next;
            decay_cnt_reg    <= decay_cnt_next;
        end
    end

    // bin division by reciprocal with one correction step
    assign c_prod_next = s_delay_reg * dcdh_pkg::DIV_RECIP;
    assign q_est       = 32'(c_prod_reg >> dcdh_pkg::DIV_SHIFT);
    assign qbw_next    = q_est * dcdh_pkg::BIN_WIDTH;
    assign rem         = d_delay_reg - d_qbw_reg;
    assign q_fix       = d_q_reg + 32'(rem >= dcdh_pkg::BIN_WIDTH);
    assign bin_next    = d_ovf_reg ? dcdh_pkg::OVF_BIN : BW'(q_fix);
    assign inrange_next = 32'(d_idx_reg) <= 32'(dcdh_pkg::NUM_BINS);

    always_comb
    begin
        if (d_cmd_reg == dcdh_pkg::CMD_READ)
        begin
            addr_next = inrange_next ? BW'(d_idx_reg) : '0;
        end
        else
        begin
            addr_next = bin_next;
        end
    end

    // histogram read-modify-write
    assign cur_count = f_fwd_hit_reg ? f_fwd_data_reg
                     : (f_ent_vld_reg ? f_mem_data_reg : 32'd0);
    assign mem_wdata = (cur_count == dcdh_pkg::COUNT_MAX) ? cur_count : cur_count + 32'd1;
    assign mem_we    = f_vld_reg && f_found_reg && g_rdy;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[f_addr_reg] <= mem_wdata;
        end
        if (f_rdy)
        begin
            f_mem_data_reg <= hist_mem[e_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg <= '0;
        end
        else if (mem_we)
        begin
            ent_vld_reg[f_addr_reg] <= 1'b1;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (i_rdy)
        begin
            i_cmd_reg <= dcdh_pkg::command_t'(item.command);
            i_qa_reg  <= item.charge_a;
            i_qb_reg  <= item.charge_b;
            i_ta_reg  <= item.time_a;
            i_tb_reg  <= item.time_b;
            i_idx_reg <= item.bin_index;
        end
        if (p_rdy)
        begin
            p_cmd_reg   <= i_cmd_reg;
            p_use_reg   <= (i_cmd_reg == dcdh_pkg::CMD_EVENT) && pass_next;
            p_coinc_reg <= coinc_next;
            p_early_reg <= early;
            p_idx_reg   <= i_idx_reg;
        end
        if (s_rdy)
        begin
            s_cmd_reg   <= p_cmd_reg;
            s_found_reg <= found_next;
            s_delay_reg <= delay[31:0];
            s_total_reg <= decay_cnt_next;
            s_idx_reg   <= p_idx_reg;
        end
        if (c_rdy)
        begin
            c_cmd_reg   <= s_cmd_reg;
            c_found_reg <= s_found_reg;
            c_ovf_reg   <= {8'd0, s_delay_reg} >= dcdh_pkg::OVF_LIMIT;
            c_delay_reg <= s_delay_reg;
            c_total_reg <= s_total_reg;
            c_prod_reg  <= c_prod_next;
            c_idx_reg   <= s_idx_reg;
        end
        if (d_rdy)
        begin
            d_cmd_reg   <= c_cmd_reg;
            d_found_reg <= c_found_reg;
            d_ovf_reg   <= c_ovf_reg;
            d_delay_reg <= c_delay_reg;
            d_total_reg <= c_total_reg;
            d_q_reg     <= q_est;
            d_qbw_reg   <= qbw_next;
            d_idx_reg   <= c_idx_reg;
        end
        if (e_rdy)
        begin
            e_cmd_reg     <= d_cmd_reg;
            e_found_reg   <= d_found_reg;
            e_inrange_reg <= inrange_next;
            e_delay_reg   <= d_delay_reg;
            e_total_reg   <= d_total_reg;
            e_addr_reg    <= addr_next;
        end
        if (f_rdy)
        begin
            f_ent_vld_reg  <= ent_vld_reg[e_addr_reg];
            f_fwd_hit_reg  <= mem_we && (f_addr_reg == e_addr_reg);
            f_fwd_data_reg <= mem_wdata;
            f_cmd_reg      <= e_cmd_reg;
            f_found_reg    <= e_found_reg;
            f_inrange_reg  <= e_inrange_reg;
            f_delay_reg    <= e_delay_reg;
            f_total_reg    <= e_total_reg;
            f_addr_reg     <= e_addr_reg;
        end
        if (g_rdy)
        begin
            g_cmd_read_reg <= f_cmd_reg == dcdh_pkg::CMD_READ;
            g_found_reg    <= f_found_reg;
            g_time_reg     <= f_found_reg ? f_delay_reg : 32'd0;
            g_bin_reg      <= f_found_reg ? 8'(f_addr_reg) : 8'd0;
            g_count_reg    <= ((f_cmd_reg == dcdh_pkg::CMD_READ) && f_inrange_reg)
                              ? cur_count : 32'd0;
            g_total_reg    <= f_total_reg;
        end
    end

    assign result.valid       = g_vld_reg;
    assign result.decay_found = g_found_reg;
    assign result.decay_time  = g_time_reg;
    assign result.decay_bin   = g_bin_reg;
    assign result.bin_count   = g_count_reg;
    assign result.decay_total = g_total_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(prompt_held_reg && decay_logged_reg))
        else $error("prompt held while a decay is logged");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> decay_cnt_reg >= $past(decay_cnt_reg))
        else $error("decay total decreased");

    a_found_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (g_vld_reg && g_found_reg) |-> (g_time_reg < cfg_decay_window_reg))
        else $error("decay outside the decay window");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (f_addr_reg <= dcdh_pkg::OVF_BIN))
        else $error("histogram write beyond the overflow bin");

    a_read_no_decay: assert property (@(posedge clk) disable iff (!rst_n)
        (g_vld_reg && g_cmd_read_reg) |-> !g_found_reg)
        else $error("read command reported a decay");

endmodule

`default_nettype wire
